@@ rtl/core/rgbs_pkg.sv @@
package rgbs_pkg;

  localparam int COORD_W = 12;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLICATE  = 3'd4;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_MIXED = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_POS  = 6'b000100,
    ST_PIX  = 6'b001000,
    ST_LERP = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    OP_X = 3'd0,
    OP_Y = 3'd1,
    OP_R = 3'd2,
    OP_G = 3'd3,
    OP_B = 3'd4
  } div_op_t;

endpackage

@@ rtl/core/rgbs_ram.sv @@
module rgbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/rgbs_div.sv @@
module rgbs_div #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r;
  logic [W:0]       rem_r;
  logic [W-1:0]     den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [W:0]       trial;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r[W-1:0], quo_r[W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        den_r <= divisor;
        rem_r <= '0;
        cnt_r <= CNT_W'(W);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= trial - {1'b0, den_r};
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[W-1:0];

endmodule

@@ rtl/core/rgb_image_scaler.sv @@
// RGB image scaler.
// in channel: in_tuser = 0 loads one pixel into the frame store at input (col,row),
// in_tuser = 1 asks for the output pixel at output (col,row). A load gives no result
// and leaves the block idle; the next item can follow in the next cycle.
// out channel: one transfer per compute request, rgb in out_tdata, status in out_tuser
// (1 when one axis shrinks while the other grows; the colour is then zero).
// Compute requests run on the shared bit-serial divider (one bit per cycle,
// at least 2*max_size_bits+8 bits wide, 34 at the default sizes):
//   enlarge: 2 divides, a position step, 4 frame store reads, each followed by
//     an accumulate, a blend step, then the output (replicate: first read only)
//   shrink or equal: 2 divides, a read and an accumulate per covered input
//     pixel, 3 divides (one per colour), then the output
// The frame store is a single-port-read memory with a registered read port;
// each covered pixel takes a read step and then an accumulate step.
// A finished result sits in the output register until taken; the block accepts the
// next item meanwhile, but holds its next result while the receiver stalls.
// Reset restores the size registers (512 x 512 to 512 x 512, bilinear) and clears the
// control state; the frame store holds garbage until loaded and needs no clearing.
// Configuration writes are taken on any cycle with cfg_we high.
module rgb_image_scaler #(
  parameter int MAX_IN_WIDTH  = 512,
  parameter int MAX_IN_HEIGHT = 512,
  parameter int MAX_OUT_SIZE  = 4096,
  parameter int FRAC_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // col[11:0], row[23:12], red_in[31:24], green_in[39:32], blue_in[47:40]
  input  logic [47:0] in_tdata,
  // req_type[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [23:0] out_tdata,
  // status[0]
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic [rgbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import rgbs_pkg::*;

  localparam int XW   = $clog2(MAX_IN_WIDTH + 1);
  localparam int YW   = $clog2(MAX_IN_HEIGHT + 1);
  localparam int OSW  = $clog2(MAX_OUT_SIZE + 1);
  localparam int SW0  = (XW > YW) ? XW : YW;
  localparam int SW   = (SW0 > OSW) ? SW0 : OSW;
  localparam int CW   = COORD_W;
  localparam int POSW = CW + SW + 1;
  localparam int STW  = SW + FRAC_BITS;
  localparam int PXW  = CW + STW;
  localparam int SUMW = CHAN_W + 2 * SW;
  localparam int DW0  = (POSW > STW) ? POSW : STW;
  localparam int DW   = (DW0 > SUMW) ? DW0 : SUMW;
  localparam int DEPTH = MAX_IN_WIDTH * MAX_IN_HEIGHT;
  localparam int AW   = $clog2(DEPTH);
  localparam int TW   = CHAN_W + FRAC_BITS + 1;
  localparam int BW   = TW + FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_IN_WIDTH);

  // input fields
  logic [CW-1:0]     in_col, in_row;
  logic [PIX_W-1:0]  in_pix;
  assign in_col = in_tdata[11:0];
  assign in_row = in_tdata[23:12];
  assign in_pix = {in_tdata[31:24], in_tdata[39:32], in_tdata[47:40]};

  // configuration
  logic [9:0]  cfg_in_width_r, cfg_in_height_r;
  logic [12:0] cfg_out_width_r, cfg_out_height_r;
  logic        cfg_replicate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_in_width_r   <= 10'd512;
      cfg_in_height_r  <= 10'd512;
      cfg_out_width_r  <= 13'd512;
      cfg_out_height_r <= 13'd512;
      cfg_replicate_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_WIDTH:   cfg_in_width_r   <= cfg_wdata[9:0];
        CFG_IN_HEIGHT:  cfg_in_height_r  <= cfg_wdata[9:0];
        CFG_OUT_WIDTH:  cfg_out_width_r  <= cfg_wdata;
        CFG_OUT_HEIGHT: cfg_out_height_r <= cfg_wdata;
        CFG_REPLICATE:  cfg_replicate_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sizes in use, clamped to 1..max
  logic [SW-1:0] ix, iy, ox, oy;
  always_comb begin
    ix = (cfg_in_width_r == '0) ? SW'(1) :
         (32'(cfg_in_width_r) > 32'(MAX_IN_WIDTH)) ? SW'(MAX_IN_WIDTH) : SW'(cfg_in_width_r);
    iy = (cfg_in_height_r == '0) ? SW'(1) :
         (32'(cfg_in_height_r) > 32'(MAX_IN_HEIGHT)) ? SW'(MAX_IN_HEIGHT) :
         SW'(cfg_in_height_r);
    ox = (cfg_out_width_r == '0) ? SW'(1) :
         (32'(cfg_out_width_r) > 32'(MAX_OUT_SIZE)) ? SW'(MAX_OUT_SIZE) :
         SW'(cfg_out_width_r);
    oy = (cfg_out_height_r == '0) ? SW'(1) :
         (32'(cfg_out_height_r) > 32'(MAX_OUT_SIZE)) ? SW'(MAX_OUT_SIZE) :
         SW'(cfg_out_height_r);
  end

  logic [CW-1:0] colc, rowc;
  logic          x_grow, y_grow, x_shrink, y_shrink, mixed, grow;
  always_comb begin
    colc = (32'(in_col) > 32'(ox) - 32'd1) ? CW'(ox - 1'b1) : in_col;
    rowc = (32'(in_row) > 32'(oy) - 32'd1) ? CW'(oy - 1'b1) : in_row;
    x_grow   = ix < ox;
    x_shrink = ix > ox;
    y_grow   = iy < oy;
    y_shrink = iy > oy;
    mixed    = (x_grow && y_shrink) || (x_shrink && y_grow);
    grow     = x_grow || y_grow;
  end

  logic in_xfer, load_xfer, comp_xfer, load_ok;
  assign in_xfer   = in_tvalid && in_tready;
  assign load_xfer = in_xfer && (in_tuser == REQ_LOAD);
  assign comp_xfer = in_xfer && (in_tuser == REQ_COMPUTE);
  assign load_ok   = (32'(in_col) < 32'(MAX_IN_WIDTH)) && (32'(in_row) < 32'(MAX_IN_HEIGHT));

  // control and datapath registers
  state_t          state_r;
  div_op_t         div_op_r;
  logic            div_start_r;
  logic [DW-1:0]   div_a_r, div_b_r;
  logic            grow_r, status_r, phase_r;
  logic [1:0]      n_r;
  logic [CW-1:0]   col_r, row_r;
  logic [POSW-1:0] xs_r, ys_r, k0pos_r, kpos_r, lpos_r;
  logic [2*SW-1:0] area_r, w_r;
  logic [DW-1:0]   qx_r;
  logic [SW-1:0]   k_r, l_r;
  logic [PXW-1:0]  px_r, py_r;
  logic [SUMW-1:0] sum_r [3];
  logic [TW-1:0]   top_r [3];
  logic [TW-1:0]   bot_r [3];
  logic [CHAN_W-1:0] rgb_r [3];
  logic            out_valid_r, out_user_r;
  logic [PIX_W-1:0] out_data_r;

  logic            div_done;
  logic [DW-1:0]   div_q, div_rem;

  rgbs_div #(.W(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (div_a_r),
    .divisor   (div_b_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // enlarge positions
  logic [PXW-FRAC_BITS-1:0] xi_raw, yi_raw;
  logic [SW-1:0]            xi, yi, xn, yn;
  logic [FRAC_BITS:0]       dx, dy;
  always_comb begin
    xi_raw = px_r[PXW-1:FRAC_BITS];
    yi_raw = py_r[PXW-1:FRAC_BITS];
    xi = (32'(xi_raw) > 32'(ix) - 32'd1) ? SW'(ix - 1'b1) : SW'(xi_raw);
    yi = (32'(yi_raw) > 32'(iy) - 32'd1) ? SW'(iy - 1'b1) : SW'(yi_raw);
    xn = ({1'b0, xi} + 1'b1 < {1'b0, ix}) ? SW'(xi + 1'b1) : SW'(ix - 1'b1);
    yn = ({1'b0, yi} + 1'b1 < {1'b0, iy}) ? SW'(yi + 1'b1) : SW'(iy - 1'b1);
    dx = {1'b0, px_r[FRAC_BITS-1:0]};
    dy = {1'b0, py_r[FRAC_BITS-1:0]};
  end

  // area coverage of the current input pixel
  logic [POSW-1:0] xe, ye, kend, lend, xlo, xhi, ylo, yhi;
  logic [SW-1:0]   wx, wy;
  always_comb begin
    xe   = xs_r + POSW'(ix);
    ye   = ys_r + POSW'(iy);
    kend = kpos_r + POSW'(ox);
    lend = lpos_r + POSW'(oy);
    xlo  = (kpos_r > xs_r) ? kpos_r : xs_r;
    xhi  = (kend < xe) ? kend : xe;
    ylo  = (lpos_r > ys_r) ? lpos_r : ys_r;
    yhi  = (lend < ye) ? lend : ye;
    wx   = SW'(xhi - xlo);
    wy   = SW'(yhi - ylo);
  end

  // frame store read address
  logic          rd_en;
  logic [SW-1:0] rd_x, rd_y;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [PIX_W-1:0] ram_q;
  always_comb begin
    rd_en = (state_r == ST_PIX) && !phase_r;
    if (grow_r) begin
      rd_x = n_r[0] ? xn : xi;
      rd_y = n_r[1] ? yn : yi;
    end else begin
      rd_x = k_r;
      rd_y = l_r;
    end
    rd_addr = AW'(rd_y) * ROW_STRIDE + AW'(rd_x);
    wr_addr = AW'(in_row) * ROW_STRIDE + AW'(in_col);
  end

  rgbs_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (load_xfer && load_ok),
    .waddr (wr_addr),
    .wdata (in_pix),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  logic [CHAN_W-1:0] pix [3];
  logic [SUMW-1:0]   sum_nxt [3];
  logic [FRAC_BITS:0] lw;
  logic [TW-1:0]     lerp_term [3];
  logic [BW-1:0]     blend [3];
  always_comb begin
    lw = n_r[0] ? dx : (ONE - dx);
    for (int c = 0; c < 3; c++) begin
      pix[c]       = ram_q[8*(2-c) +: 8];
      sum_nxt[c]   = sum_r[c] + SUMW'(pix[c]) * SUMW'(w_r);
      lerp_term[c] = TW'(pix[c]) * TW'(lw);
      blend[c]     = BW'(top_r[c]) * BW'(ONE - dy) + BW'(bot_r[c]) * BW'(dy);
    end
  end

  logic row_last, col_last, out_free;
  assign col_last = ({1'b0, k_r} + 1'b1 >= {1'b0, ix}) || (kend >= xe);
  assign row_last = ({1'b0, l_r} + 1'b1 >= {1'b0, iy}) || (lend >= ye);
  assign out_free = !out_valid_r || out_tready;

  // divider starts: first axis, second axis, then one per colour when shrinking
  logic div_start_nxt, out_valid_nxt;
  assign div_start_nxt = ((state_r == ST_IDLE) && comp_xfer && !mixed) ||
                         ((state_r == ST_DIV) && div_done &&
                          ((div_op_r == OP_X) || (div_op_r == OP_R) || (div_op_r == OP_G))) ||
                         ((state_r == ST_PIX) && phase_r && !grow_r && col_last && row_last);
  assign out_valid_nxt = ((state_r == ST_DONE) && out_free) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_op_r    <= OP_X;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      n_r         <= '0;
    end else begin
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (comp_xfer) begin
            col_r    <= colc;
            row_r    <= rowc;
            grow_r   <= grow;
            xs_r     <= POSW'(colc) * POSW'(ix);
            ys_r     <= POSW'(rowc) * POSW'(iy);
            area_r   <= (2*SW)'(ix) * (2*SW)'(iy);
            for (int c = 0; c < 3; c++) begin
              rgb_r[c] <= '0;
            end
            if (mixed) begin
              status_r <= STATUS_MIXED;
              state_r  <= ST_DONE;
            end else begin
              status_r    <= STATUS_OK;
              div_op_r    <= OP_X;
              div_a_r     <= grow ? (DW'(ix - 1'b1) << FRAC_BITS)
                                  : DW'(POSW'(colc) * POSW'(ix));
              div_b_r     <= DW'(ox);
              state_r     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            unique case (div_op_r)
              OP_X: begin
                qx_r        <= div_q;
                k0pos_r     <= xs_r - POSW'(div_rem);
                div_op_r    <= OP_Y;
                div_a_r     <= grow_r ? (DW'(iy - 1'b1) << FRAC_BITS) : DW'(ys_r);
                div_b_r     <= DW'(oy);
              end
              OP_Y: begin
                if (grow_r) begin
                  py_r    <= PXW'(row_r) * PXW'(div_q[STW-1:0]);
                  state_r <= ST_POS;
                end else begin
                  k_r     <= qx_r[SW-1:0];
                  kpos_r  <= k0pos_r;
                  l_r     <= div_q[SW-1:0];
                  lpos_r  <= ys_r - POSW'(div_rem);
                  phase_r <= 1'b0;
                  for (int c = 0; c < 3; c++) begin
                    sum_r[c] <= '0;
                  end
                  state_r <= ST_PIX;
                end
              end
              OP_R: begin
                rgb_r[0]    <= div_q[CHAN_W-1:0];
                div_op_r    <= OP_G;
                div_a_r     <= DW'(sum_r[1]);
              end
              OP_G: begin
                rgb_r[1]    <= div_q[CHAN_W-1:0];
                div_op_r    <= OP_B;
                div_a_r     <= DW'(sum_r[2]);
              end
              OP_B: begin
                rgb_r[2] <= div_q[CHAN_W-1:0];
                state_r  <= ST_DONE;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_POS: begin
          px_r    <= PXW'(col_r) * PXW'(qx_r[STW-1:0]);
          n_r     <= '0;
          phase_r <= 1'b0;
          for (int c = 0; c < 3; c++) begin
            top_r[c] <= '0;
            bot_r[c] <= '0;
          end
          state_r <= ST_PIX;
        end
        ST_PIX: begin
          if (!phase_r) begin
            w_r     <= (2*SW)'(wx) * (2*SW)'(wy);
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            if (grow_r) begin
              if (cfg_replicate_r) begin
                for (int c = 0; c < 3; c++) begin
                  rgb_r[c] <= pix[c];
                end
                state_r <= ST_DONE;
              end else begin
                for (int c = 0; c < 3; c++) begin
                  if (n_r[1]) begin
                    bot_r[c] <= bot_r[c] + lerp_term[c];
                  end else begin
                    top_r[c] <= top_r[c] + lerp_term[c];
                  end
                end
                n_r <= n_r + 1'b1;
                if (n_r == 2'd3) begin
                  state_r <= ST_LERP;
                end
              end
            end else begin
              for (int c = 0; c < 3; c++) begin
                sum_r[c] <= sum_nxt[c];
              end
              if (col_last) begin
                k_r    <= qx_r[SW-1:0];
                kpos_r <= k0pos_r;
                l_r    <= l_r + 1'b1;
                lpos_r <= lend;
                if (row_last) begin
                  div_op_r    <= OP_R;
                  div_a_r     <= DW'(sum_nxt[0]);
                  div_b_r     <= DW'(area_r);
                  state_r     <= ST_DIV;
                end
              end else begin
                k_r    <= k_r + 1'b1;
                kpos_r <= kend;
              end
            end
          end
        end
        ST_LERP: begin
          for (int c = 0; c < 3; c++) begin
            rgb_r[c] <= blend[c][2*FRAC_BITS +: CHAN_W];
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_r  <= {rgb_r[2], rgb_r[1], rgb_r[0]};
            out_user_r  <= status_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // divider reports only while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside divide wait");

  // pixel data is consumed only the cycle after its read
  a_read_before_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIX) && phase_r |-> $past(rd_en))
    else $error("frame store data used without a read");

  // a finished result always reaches the output register
  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not handed to output");

endmodule
